// ===== design/swlp95_pkg.sv =====
// ----------------------------------------------------------------------------
// swlp95_pkg
// types and constants shared by the sliding window p95 latency block
// ----------------------------------------------------------------------------
`default_nettype none

package swlp95_pkg;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DRD,
    ST_DEL,
    ST_INS,
    ST_CHK,
    ST_RANK,
    ST_SEL,
    ST_OUT
  } swlp95_state_t;

  localparam int unsigned CFG_W       = 9;
  localparam int unsigned COUNT_W     = 32;
  localparam int unsigned SCOUNT_W    = 9;
  localparam int unsigned WINDOW_RST  = 256;

  // floor(x / 5) = (x * RECIP5) >> RECIP5_SHIFT, exact for x below 16384
  localparam int unsigned RECIP5_W     = 12;
  localparam logic [RECIP5_W-1:0] RECIP5 = 12'd3277;
  localparam int unsigned RECIP5_SHIFT = 14;

endpackage

`default_nettype wire

// ===== design/sliding_window_latency_p95.sv =====
// ----------------------------------------------------------------------------
// sliding_window_latency_p95
// nearest-rank 95th percentile of request latency over a sliding window
// ----------------------------------------------------------------------------
// an accepted item is placed by an insert pass over the sorted sample memory,
// then come the check, rank, select and output states; a full window first
// drops its oldest sample in a delete pass. each extra sample dropped after a
// window shrink adds a further delete pass and check. busy falls in the done
// cycle, so a new item is taken only once the last one is through; the passes
// over the sorted sample memory set the pace. results are strobed for one
// cycle on done and cannot be stalled. synchronous reset clears the counters,
// the window and the sequencer; window_size resets to 256.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_latency_p95
  import swlp95_pkg::*;
#(
  parameter int unsigned WINDOW_MAX   = 256,
  parameter int unsigned LATENCY_BITS = 24
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  // configuration write
  input  wire logic                    cfg_we,
  input  wire logic [CFG_W-1:0]        cfg_wdata,
  // item in
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [LATENCY_BITS-1:0] latency,
  input  wire logic                    request_ok,
  input  wire logic                    accepted,
  // result out
  output logic                         done,
  output logic [LATENCY_BITS-1:0]      p95_latency,
  output logic [SCOUNT_W-1:0]          sample_count,
  output logic [COUNT_W-1:0]           requests_total,
  output logic [COUNT_W-1:0]           errors_total,
  output logic [COUNT_W-1:0]           rejections_total
);

  // held count needs to reach WINDOW_MAX itself, an index only WINDOW_MAX-1
  localparam int unsigned HC_W  = $clog2(WINDOW_MAX + 1);
  localparam int unsigned IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int unsigned LIM_W = (HC_W > CFG_W) ? HC_W : CFG_W;
  localparam int unsigned PRD_W = HC_W + RECIP5_W;

  // two memories: insertion order (ring) and ascending order (sorted)
  logic [LATENCY_BITS-1:0] ring_mem [WINDOW_MAX];
  logic [LATENCY_BITS-1:0] srt_mem  [WINDOW_MAX];
  logic [LATENCY_BITS-1:0] ring_q;
  logic [LATENCY_BITS-1:0] srt_q;

  // memory controls
  logic                    ring_re;
  logic                    ring_we;
  logic [IDX_W-1:0]        ring_waddr;
  logic                    srt_re;
  logic [IDX_W-1:0]        srt_raddr;
  logic                    srt_we;
  logic [IDX_W-1:0]        srt_waddr;
  logic [LATENCY_BITS-1:0] srt_wdata;

  // sequencer and window state
  swlp95_state_t           state, state_next;
  logic [CFG_W-1:0]        window_size;
  logic [IDX_W-1:0]        oldest, oldest_next;
  logic [HC_W-1:0]         held, held_next;
  logic [HC_W-1:0]         cnt, cnt_next;       // pass read counter
  logic [HC_W-1:0]         wcnt, wcnt_next;     // delete pass write pointer
  logic [IDX_W-1:0]        pk, pk_next;         // index of data in srt_q
  logic                    pv, pv_next;         // srt_q holds pass data
  logic                    found, found_next;   // dropped value already skipped
  logic                    pre, pre_next;       // drop before insert (full ring)
  logic [LATENCY_BITS-1:0] lat_q, lat_next;
  logic [PRD_W-1:0]        prod, prod_next;
  logic [LATENCY_BITS-1:0] p95_next;
  logic                    done_next;
  logic [COUNT_W-1:0]      req_next, err_next, rej_next;

  // derived conditions
  logic                    accept;
  logic                    full;
  logic [LIM_W-1:0]        limit;
  logic                    over_limit;
  logic                    del_end;
  logic                    ins_place;
  logic                    ins_end;
  logic [HC_W:0]           tail_sum;
  logic [HC_W-1:0]         div20;
  logic [HC_W-1:0]         rank;
  logic [IDX_W-1:0]        oldest_inc;

  assign accept = start && !busy;
  assign full   = (held >= HC_W'(WINDOW_MAX));

  // zero acts as one, anything above the memory depth acts as the depth
  always_comb begin
    limit = (window_size == '0) ? LIM_W'(1) : LIM_W'(window_size);
    if (limit > LIM_W'(WINDOW_MAX)) begin
      limit = LIM_W'(WINDOW_MAX);
    end
  end

  assign over_limit = (LIM_W'(held) > limit);

  // delete pass ends once every read is issued and the last one processed
  assign del_end   = (state == ST_DEL) && !pv && (cnt == held);
  // insert pass walks down and stops at the first entry not above the item
  assign ins_place = pv && !(srt_q > lat_q);
  assign ins_end   = (state == ST_INS) && (ins_place || (!pv && cnt == '0));

  // ring slot for the new sample: (oldest + held) mod depth
  assign tail_sum = (HC_W + 1)'(oldest) + (HC_W + 1)'(held);
  always_comb begin
    if (tail_sum >= (HC_W + 1)'(WINDOW_MAX)) begin
      ring_waddr = IDX_W'(tail_sum - (HC_W + 1)'(WINDOW_MAX));
    end else begin
      ring_waddr = IDX_W'(tail_sum);
    end
  end

  assign oldest_inc = (oldest == IDX_W'(WINDOW_MAX - 1)) ? '0 : oldest + 1'b1;

  // rank = ceil(0.95 n) = n - floor(n / 20) = n - floor((n >> 2) / 5)
  assign div20 = HC_W'(prod >> RECIP5_SHIFT);
  assign rank  = held - div20;

  assign busy         = (state != ST_IDLE);
  assign sample_count = SCOUNT_W'(held);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = full ? ST_DRD : ST_INS;
        end
      end
      ST_DRD:  state_next = ST_DEL;
      ST_DEL: begin
        if (del_end) begin
          state_next = pre ? ST_INS : ST_CHK;
        end
      end
      ST_INS: begin
        if (ins_end) begin
          state_next = ST_CHK;
        end
      end
      ST_CHK:  state_next = over_limit ? ST_DRD : ST_RANK;
      ST_RANK: state_next = ST_SEL;
      ST_SEL:  state_next = ST_OUT;
      ST_OUT:  state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    ring_re    = 1'b0;
    ring_we    = 1'b0;
    srt_re     = 1'b0;
    srt_raddr  = '0;
    srt_we     = 1'b0;
    srt_waddr  = '0;
    srt_wdata  = lat_q;
    oldest_next = oldest;
    held_next  = held;
    cnt_next   = cnt;
    wcnt_next  = wcnt;
    pk_next    = pk;
    pv_next    = 1'b0;
    found_next = found;
    pre_next   = pre;
    lat_next   = lat_q;
    prod_next  = prod;
    p95_next   = p95_latency;
    done_next  = 1'b0;
    req_next   = requests_total;
    err_next   = errors_total;
    rej_next   = rejections_total;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          lat_next = latency;
          pre_next = full;
          cnt_next = held;
          if (requests_total != '1) begin
            req_next = requests_total + 1'b1;
          end
          if (!request_ok && errors_total != '1) begin
            err_next = errors_total + 1'b1;
          end
          if (!accepted && rejections_total != '1) begin
            rej_next = rejections_total + 1'b1;
          end
        end
      end

      ST_DRD: begin
        // fetch the oldest sample, the value to take out of the sorted list
        ring_re    = 1'b1;
        cnt_next   = '0;
        wcnt_next  = '0;
        found_next = 1'b0;
      end

      ST_DEL: begin
        if (cnt < held) begin
          srt_re    = 1'b1;
          srt_raddr = IDX_W'(cnt);
          cnt_next  = cnt + 1'b1;
          pv_next   = 1'b1;
        end
        // compact in place, skipping one copy of the dropped value
        if (pv) begin
          if (!found && srt_q == ring_q) begin
            found_next = 1'b1;
          end else begin
            srt_we    = 1'b1;
            srt_waddr = IDX_W'(wcnt);
            srt_wdata = srt_q;
            wcnt_next = wcnt + 1'b1;
          end
        end
        if (del_end) begin
          oldest_next = oldest_inc;
          held_next   = held - 1'b1;
          cnt_next    = held - 1'b1;
        end
      end

      ST_INS: begin
        if (cnt != '0 && !ins_place) begin
          srt_re    = 1'b1;
          srt_raddr = IDX_W'(cnt - 1'b1);
          pk_next   = IDX_W'(cnt - 1'b1);
          cnt_next  = cnt - 1'b1;
          pv_next   = 1'b1;
        end
        // shift larger entries up by one, drop the item into the gap
        if (pv) begin
          srt_we    = 1'b1;
          srt_waddr = pk + 1'b1;
          srt_wdata = ins_place ? lat_q : srt_q;
        end else if (ins_end) begin
          srt_we    = 1'b1;
          srt_waddr = '0;
          srt_wdata = lat_q;
        end
        if (ins_end) begin
          ring_we   = 1'b1;
          held_next = held + 1'b1;
          pre_next  = 1'b0;
        end
      end

      ST_CHK: begin
        pre_next = 1'b0;
      end

      ST_RANK: begin
        prod_next = PRD_W'(held >> 2) * PRD_W'(RECIP5);
      end

      ST_SEL: begin
        srt_re    = 1'b1;
        srt_raddr = IDX_W'(rank - 1'b1);
      end

      ST_OUT: begin
        p95_next  = srt_q;
        done_next = 1'b1;
      end

      default: begin
      end
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[ring_waddr] <= lat_q;
    end
    if (ring_re) begin
      ring_q <= ring_mem[oldest];
    end
  end

  always_ff @(posedge clk) begin
    if (srt_we) begin
      srt_mem[srt_waddr] <= srt_wdata;
    end
    if (srt_re) begin
      srt_q <= srt_mem[srt_raddr];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      window_size      <= CFG_W'(WINDOW_RST);
      oldest           <= '0;
      held             <= '0;
      cnt              <= '0;
      wcnt             <= '0;
      pv               <= 1'b0;
      found            <= 1'b0;
      pre              <= 1'b0;
      done             <= 1'b0;
      requests_total   <= '0;
      errors_total     <= '0;
      rejections_total <= '0;
    end else begin
      state            <= state_next;
      if (cfg_we) begin
        window_size    <= cfg_wdata;
      end
      oldest           <= oldest_next;
      held             <= held_next;
      cnt              <= cnt_next;
      wcnt             <= wcnt_next;
      pv               <= pv_next;
      found            <= found_next;
      pre              <= pre_next;
      done             <= done_next;
      requests_total   <= req_next;
      errors_total     <= err_next;
      rejections_total <= rej_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pk          <= pk_next;
    lat_q       <= lat_next;
    prod        <= prod_next;
    p95_latency <= p95_next;
  end

endmodule

`default_nettype wire
